### hdl/crc_checked_frame_receiver_assert.svh
// assertion macros for the crc checked frame receiver
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define CCFR_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define CCFR_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define CCFR_CHECK(lbl, prop, msg)

`define CCFR_CHECK_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/crc_cfr_pkg.sv
// shared types and constants for the crc checked frame receiver
package crc_cfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h55;
    localparam logic [CRC_W-1:0]  CRC_SEED_RST    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED    = 2'd2;

    typedef struct packed {
        logic             load_seed;
        logic             crc_feed;
        logic             crc_shift;
        logic             low_latch;
        logic             out_load_ok;
        logic             out_load_err;
        logic             last_beat;
        logic [CNT_W-1:0] wr_idx;
        logic [CNT_W-1:0] rd_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic crc_match;
    } t_dp_stat;

endpackage

### hdl/crc_cfr_rx_if.sv
// received byte channel
interface crc_cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/crc_cfr_res_if.sv
// result channel
interface crc_cfr_res_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] frame_flags;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;

    modport source (output valid, output status, output frame_flags, output payload_byte,
                    output byte_index, output last, input ready);
    modport sink (input valid, input status, input frame_flags, input payload_byte,
                  input byte_index, input last, output ready);
endinterface

### hdl/crc_cfr_ram.sv
// generic single write port ram with registered read
module crc_cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/crc_cfr_dp.sv
// datapath: config registers, bit-serial crc, body store and result register
module crc_cfr_dp #(
    parameter int BLOB_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crc_cfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crc_cfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [crc_cfr_pkg::BYTE_W-1:0]      i_rx_byte,
    input  crc_cfr_pkg::t_dp_cmd                i_cmd,
    output crc_cfr_pkg::t_dp_stat               o_stat,
    output logic                                o_status,
    output logic [crc_cfr_pkg::BYTE_W-1:0]      o_frame_flags,
    output logic [crc_cfr_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [crc_cfr_pkg::CNT_W-1:0]       o_byte_index,
    output logic                                o_last
);
    import crc_cfr_pkg::*;

    localparam int DEPTH  = BLOB_BYTES + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_first_sync;
    logic [BYTE_W-1:0] r_second_sync;
    logic [CRC_W-1:0]  r_crc_seed;
    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_crc_low;
    logic [BYTE_W-1:0] r_flags;
    logic              r_status;
    logic [BYTE_W-1:0] r_flags_out;
    logic [BYTE_W-1:0] r_payload;
    logic [CNT_W-1:0]  r_index;
    logic              r_last;

    logic [CNT_W-1:0]  w_rd_next;
    logic [BYTE_W-1:0] w_rdata;
    logic [CRC_W-1:0]  w_crc_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= FIRST_SYNC_RST;
            r_second_sync <= SECOND_SYNC_RST;
            r_crc_seed    <= CRC_SEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_SYNC:  r_first_sync  <= i_cfg_data[BYTE_W-1:0];
                CFG_SECOND_SYNC: r_second_sync <= i_cfg_data[BYTE_W-1:0];
                CFG_CRC_SEED:    r_crc_seed    <= i_cfg_data[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_crc_sh = r_crc[CRC_W-1] ? ({r_crc[CRC_W-2:0], 1'b0} ^ CRC_POLY)
                                     : {r_crc[CRC_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_crc <= r_crc_seed;
        end else if (i_cmd.crc_feed) begin
            r_crc <= r_crc ^ {i_rx_byte, {BYTE_W{1'b0}}};
        end else if (i_cmd.crc_shift) begin
            r_crc <= w_crc_sh;
        end
        if (i_cmd.low_latch) begin
            r_crc_low <= i_rx_byte;
        end
        if (i_cmd.crc_feed && (i_cmd.wr_idx == '0)) begin
            r_flags <= i_rx_byte;
        end
    end

    assign w_rd_next = i_cmd.rd_idx + CNT_W'(1);

    crc_cfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_body_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.crc_feed),
        .i_waddr (i_cmd.wr_idx[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (w_rd_next[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_ok) begin
            r_status    <= 1'b0;
            r_flags_out <= r_flags;
            r_payload   <= w_rdata;
            r_index     <= i_cmd.rd_idx;
            r_last      <= i_cmd.last_beat;
        end else if (i_cmd.out_load_err) begin
            r_status    <= 1'b1;
            r_flags_out <= r_flags;
            r_payload   <= '0;
            r_index     <= '0;
            r_last      <= 1'b1;
        end
    end

    assign o_stat.sync1_hit = (i_rx_byte == r_first_sync);
    assign o_stat.sync2_hit = (i_rx_byte == r_second_sync);
    assign o_stat.crc_match = ({i_rx_byte, r_crc_low} == r_crc);

    assign o_status       = r_status;
    assign o_frame_flags  = r_flags_out;
    assign o_payload_byte = r_payload;
    assign o_byte_index   = r_index;
    assign o_last         = r_last;

endmodule

### hdl/crc_cfr_ctrl.sv
// controller: frame parser and result sequencer
module crc_cfr_ctrl #(
    parameter int BLOB_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    input  crc_cfr_pkg::t_dp_stat i_stat,
    output crc_cfr_pkg::t_dp_cmd  o_cmd
);
    import crc_cfr_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BODY = CNT_W'(BLOB_BYTES);
    localparam logic [CNT_W-1:0] LOW_POS   = CNT_W'(BLOB_BYTES + 1);
    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(BLOB_BYTES - 1);

    typedef enum logic [2:0] {S_IDLE, S_CRC, S_ERR, S_RD, S_LD} t_state;
    typedef enum logic [1:0] {PH_HUNT1, PH_HUNT2, PH_BODY} t_phase;

    t_state           r_state;
    t_phase           r_phase;
    logic [CNT_W-1:0] r_count;
    logic [2:0]       r_bit;
    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;

    logic w_accept;
    logic w_out_free;

    assign w_accept   = i_rx_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_res_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_idx    = r_count;
        o_cmd.rd_idx    = r_idx;
        o_cmd.last_beat = (r_idx == LAST_IDX);
        if (w_accept && (r_phase == PH_HUNT2) && i_stat.sync2_hit) begin
            o_cmd.load_seed = 1'b1;
        end
        if (w_accept && (r_phase == PH_BODY)) begin
            if (r_count <= LAST_BODY) begin
                o_cmd.crc_feed = 1'b1;
            end else if (r_count == LOW_POS) begin
                o_cmd.low_latch = 1'b1;
            end
        end
        o_cmd.crc_shift    = (r_state == S_CRC);
        o_cmd.out_load_err = (r_state == S_ERR) && w_out_free;
        o_cmd.out_load_ok  = (r_state == S_LD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HUNT1;
            r_count     <= '0;
            r_bit       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load_ok || o_cmd.out_load_err) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_rx_valid) begin
                        unique case (r_phase)
                            PH_HUNT2: begin
                                if (i_stat.sync2_hit) begin
                                    r_count <= '0;
                                    r_phase <= PH_BODY;
                                end else begin
                                    r_phase <= PH_HUNT1;
                                end
                            end
                            PH_BODY: begin
                                if (r_count <= LAST_BODY) begin
                                    r_count <= r_count + CNT_W'(1);
                                    r_bit   <= '0;
                                    r_state <= S_CRC;
                                end else if (r_count == LOW_POS) begin
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_phase <= PH_HUNT1;
                                    r_count <= '0;
                                    r_idx   <= '0;
                                    r_state <= i_stat.crc_match ? S_RD : S_ERR;
                                end
                            end
                            default: begin
                                r_phase <= i_stat.sync1_hit ? PH_HUNT2 : PH_HUNT1;
                            end
                        endcase
                    end
                end
                S_CRC: begin
                    r_bit <= r_bit + 3'd1;
                    if (&r_bit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    if (w_out_free) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rx_ready  = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

endmodule

### hdl/crc_checked_frame_receiver.sv
// top level of the crc checked frame receiver
//
// i_rx carries one received serial byte per beat (valid/ready). the block hunts
// for the first and second sync bytes, then collects a flags byte, BLOB_BYTES
// payload bytes and a little-endian crc-16-ccitt over flags and payload.
// o_res carries results: on a good crc one beat per payload byte with the
// frame flags, byte index and last on the final byte; on a bad crc a single
// beat with status set, payload and index zero and last set.
// sync bytes and the crc low byte are simply accepted; each flags or payload byte
// is accepted and then shifted through the bit-serial crc shift register.
// the final crc byte starts emission: each payload result is a body ram read
// then a load of the result register, the error result a load of the result register alone.
// the input is not ready while a byte is in the crc loop or results are being
// issued; once the last result sits in the result register the next byte is
// taken again. a stalled receiver holds the result register and the sequencer
// waits for it. the cfg port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the two
// sync bytes and the crc seed. synchronous reset returns to sync hunting,
// empties the result register and restores the default register values.
module crc_checked_frame_receiver #(
    parameter int BLOB_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    crc_cfr_rx_if.sink                          i_rx,
    crc_cfr_res_if.source                       o_res,
    input  logic                                i_cfg_we,
    input  logic [crc_cfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crc_cfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import crc_cfr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_rx_ready;
    logic     w_res_valid;
    logic     w_res_load;

    crc_cfr_ctrl #(
        .BLOB_BYTES (BLOB_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx.valid),
        .o_rx_ready  (w_rx_ready),
        .i_res_ready (o_res.ready),
        .o_res_valid (w_res_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    crc_cfr_dp #(
        .BLOB_BYTES (BLOB_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx.rx_byte),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_status       (o_res.status),
        .o_frame_flags  (o_res.frame_flags),
        .o_payload_byte (o_res.payload_byte),
        .o_byte_index   (o_res.byte_index),
        .o_last         (o_res.last)
    );

    assign i_rx.ready  = w_rx_ready;
    assign o_res.valid = w_res_valid;
    assign w_res_load  = w_cmd.out_load_ok || w_cmd.out_load_err;

    `include "crc_checked_frame_receiver_assert.svh"

    `CCFR_CHECK(a_feed_then_busy, w_cmd.crc_feed |=> !i_rx.ready, "input ready during crc shift")
    `CCFR_CHECK(a_no_overwrite, w_res_load |-> (!o_res.valid || o_res.ready), "result overwritten")
    `CCFR_CHECK_ALWAYS(a_reset_empty, !i_rst_n |=> !o_res.valid, "result valid after reset")

endmodule
